/* sv/facft_pkg.sv */
package facft_pkg;

    localparam int REGIONS_DEFAULT   = 16;
    localparam int ADDR_BITS_DEFAULT = 16;
    localparam int FIELD_BITS        = 16;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 16;

    localparam logic [FIELD_BITS-1:0] GAP_RESET         = 16'd5;
    localparam logic [FIELD_BITS-1:0] MEMORY_SIZE_RESET = 16'hFFFF;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic {
        POLICY_FIRST = 1'b0,
        POLICY_NEXT  = 1'b1
    } policy_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_FIT     = 2'd1,
        STATUS_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FIT_POLICY  = 2'd0,
        REG_GAP         = 2'd1,
        REG_MEMORY_SIZE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic neg;
        logic eq;
    } alu_flags_t;

    typedef struct packed {
        cmd_t                  command;
        logic [FIELD_BITS-1:0] size;
        logic [FIELD_BITS-1:0] base;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [FIELD_BITS-1:0] grant_base;
        logic [FIELD_BITS-1:0] grant_size;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_RD,
        ST_A_FIT,
        ST_A_GAP,
        ST_A_SPLIT,
        ST_F_RD,
        ST_F_LOW,
        ST_F_ORD,
        ST_F_HIGH,
        ST_F_NRD,
        ST_F_NCHK,
        ST_F_SUM1,
        ST_F_SUM2,
        ST_INS,
        ST_SH_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_WR,
        ST_RM_END,
        ST_DONE
    } state_t;

    // operand width of the shared unit: room for the wider of an address and the gap field, plus one carry bit
    function automatic int operand_width(input int addr_bits);
        int w;
        w = (addr_bits > FIELD_BITS) ? addr_bits : FIELD_BITS;
        return w + 1;
    endfunction

endpackage

/* sv/fit_allocator_coalescing_free_table.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  facft_pkg::req_t  (command, size, base)
// rsp       out        rsp_valid / rsp_stall  facft_pkg::rsp_t  (status, grant_base, grant_size)
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// One request at a time. An allocate reads and tests each table entry in turn until one fits
// or none is left, then checks the gap and either splits the region or grants it whole and
// shifts the later entries down. A free walks the entries, checks the neighbours below and
// above for a merge, and shifts entries up on insert or down on merge removal.
// Those steps follow from the table, which has one read port with a registered read, and the one
// shared adder that does every address compare and sum. Reset and each memory_size write run a
// one-cycle init of entry 0 while req_stall is high. A finished result waits in the
// output register, so rsp_stall only delays the next request once a second result is due.
module fit_allocator_coalescing_free_table #(
    parameter int REGIONS   = facft_pkg::REGIONS_DEFAULT,
    parameter int ADDR_BITS = facft_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  facft_pkg::req_t                       req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output facft_pkg::rsp_t                       rsp,
    input  logic                                  cfg_we,
    input  logic [facft_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [facft_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int W  = ADDR_BITS;
    localparam int OW = facft_pkg::operand_width(ADDR_BITS);
    localparam int IW = $clog2(REGIONS);
    localparam int CW = $clog2(REGIONS + 1);
    localparam int EW = 2 * ADDR_BITS;

    // configuration
    facft_pkg::policy_t fit_policy_reg;
    logic [15:0]        gap_reg;
    logic [15:0]        msize_reg;

    // control state
    facft_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      rover_reg, rover_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // working registers of the current request
    facft_pkg::cmd_t    cmd_reg, cmd_next;
    logic [W-1:0]       size_reg, size_next;
    logic [W-1:0]       base_reg, base_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [CW-1:0]      sh_reg, sh_next;
    logic               ins_reg, ins_next;
    logic               hi_reg, hi_next;
    logic               dbl_reg, dbl_next;
    logic [W-1:0]       start_reg, start_next;
    logic [W-1:0]       len_reg, len_next;
    logic [W-1:0]       left_reg, left_next;
    logic [W-1:0]       nlen_reg, nlen_next;
    facft_pkg::status_t status_reg, status_next;
    logic [15:0]        gbase_reg, gbase_next;
    logic [15:0]        gsize_reg, gsize_next;
    facft_pkg::rsp_t    rsp_reg, rsp_next;

    // table port
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [EW-1:0]      ram_rdata;

    // shared unit
    facft_pkg::alu_op_t    alu_op;
    logic [OW-1:0]         alu_a;
    logic [OW-1:0]         alu_b;
    logic [W-1:0]          alu_c;
    logic [W-1:0]          alu_wrap;
    logic [W-1:0]          alu_sat;
    facft_pkg::alu_flags_t alu_flags;

    // helpers
    logic [W-1:0]  req_size_w;
    logic [W-1:0]  req_base_w;
    logic [W-1:0]  mem_len;
    logic [W-1:0]  rd_start;
    logic [W-1:0]  rd_len;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] k_inc;
    logic [IW-1:0] k_wrap;
    logic [CW-1:0] sh_inc;
    logic [CW-1:0] sh_dec;
    logic [CW-1:0] count_dec;
    logic [IW-1:0] rov_cand;

    facft_ram #(
        .DEPTH (REGIONS),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    facft_alu #(
        .ADDR_BITS (ADDR_BITS)
    ) u_alu (
        .op       (alu_op),
        .a        (alu_a),
        .b        (alu_b),
        .c        (alu_c),
        .sum_wrap (alu_wrap),
        .sum_sat  (alu_sat),
        .flags    (alu_flags)
    );

    // addresses and sizes live at ADDR_BITS inside; the ports stay 16 bits
    assign req_size_w = W'(req.size);
    assign req_base_w = W'(req.base);
    assign mem_len    = W'(msize_reg);
    assign rd_start   = ram_rdata[EW-1:W];
    assign rd_len     = ram_rdata[W-1:0];
    assign idx_inc    = idx_reg + CW'(1);
    assign k_inc      = CW'(k_reg) + CW'(1);
    assign k_wrap     = (k_inc == count_reg) ? '0 : k_inc[IW-1:0];
    assign sh_inc     = sh_reg + CW'(1);
    assign sh_dec     = sh_reg - CW'(1);
    assign count_dec  = count_reg - CW'(1);
    // a whole-region grant moves the rover to the granted slot; a merge keeps it
    assign rov_cand   = (cmd_reg == facft_pkg::CMD_ALLOC) ? k_reg : rover_reg;

    assign req_stall  = (state_reg != facft_pkg::ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= facft_pkg::POLICY_FIRST;
            gap_reg        <= facft_pkg::GAP_RESET;
            msize_reg      <= facft_pkg::MEMORY_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                facft_pkg::REG_FIT_POLICY:  fit_policy_reg <= facft_pkg::policy_t'(cfg_data[0]);
                facft_pkg::REG_GAP:         gap_reg        <= cfg_data;
                facft_pkg::REG_MEMORY_SIZE: msize_reg      <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= facft_pkg::ST_INIT;
            count_reg     <= '0;
            rover_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rover_reg     <= rover_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        size_reg   <= size_next;
        base_reg   <= base_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        sh_reg     <= sh_next;
        ins_reg    <= ins_next;
        hi_reg     <= hi_next;
        dbl_reg    <= dbl_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        left_reg   <= left_next;
        nlen_reg   <= nlen_next;
        status_reg <= status_next;
        gbase_reg  <= gbase_next;
        gsize_reg  <= gsize_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rover_next     = rover_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        sh_next        = sh_reg;
        ins_next       = ins_reg;
        hi_next        = hi_reg;
        dbl_next       = dbl_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        nlen_next      = nlen_reg;
        status_next    = status_reg;
        gbase_next     = gbase_reg;
        gsize_next     = gsize_reg;
        rsp_next       = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        alu_op    = facft_pkg::ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;
        alu_c     = '0;

        // drop the result once it transfers
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            facft_pkg::ST_INIT:
            begin
                // table becomes the single region [0, memory_size), or empty
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = {{W{1'b0}}, mem_len};
                count_next = (mem_len != '0) ? CW'(1) : '0;
                rover_next = '0;
                state_next = facft_pkg::ST_IDLE;
            end

            facft_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req.command;
                    size_next   = req_size_w;
                    base_next   = req_base_w;
                    idx_next    = '0;
                    status_next = facft_pkg::STATUS_OK;
                    gbase_next  = '0;
                    gsize_next  = '0;
                    if (req.command == facft_pkg::CMD_ALLOC)
                    begin
                        if (req_size_w == '0 || count_reg == '0)
                        begin
                            status_next = facft_pkg::STATUS_NO_FIT;
                            state_next  = facft_pkg::ST_DONE;
                        end
                        else
                        begin
                            // next fit starts at the rover, clamped into the table
                            if (fit_policy_reg == facft_pkg::POLICY_NEXT &&
                                CW'(rover_reg) < count_reg)
                            begin
                                k_next = rover_reg;
                            end
                            else
                            begin
                                k_next = '0;
                            end
                            state_next = facft_pkg::ST_A_RD;
                        end
                    end
                    else
                    begin
                        if (req_size_w == '0)
                        begin
                            state_next = facft_pkg::ST_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = facft_pkg::ST_INS;
                        end
                        else
                        begin
                            state_next = facft_pkg::ST_F_RD;
                        end
                    end
                end
            end

            facft_pkg::ST_A_RD:
            begin
                ram_raddr  = k_reg;
                state_next = facft_pkg::ST_A_FIT;
            end

            facft_pkg::ST_A_FIT:
            begin
                // length - size: no borrow means the region fits
                alu_op     = facft_pkg::ALU_SUB;
                alu_a      = OW'(rd_len);
                alu_b      = OW'(size_reg);
                start_next = rd_start;
                len_next   = rd_len;
                left_next  = alu_wrap;
                if (!alu_flags.neg)
                begin
                    state_next = facft_pkg::ST_A_GAP;
                end
                else if (idx_inc == count_reg)
                begin
                    status_next = facft_pkg::STATUS_NO_FIT;
                    state_next  = facft_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    k_next     = k_wrap;
                    state_next = facft_pkg::ST_A_RD;
                end
            end

            facft_pkg::ST_A_GAP:
            begin
                // gap - leftover: no borrow means grant the whole region
                alu_op     = facft_pkg::ALU_SUB;
                alu_a      = OW'(gap_reg);
                alu_b      = OW'(left_reg);
                gbase_next = 16'(start_reg);
                if (!alu_flags.neg)
                begin
                    gsize_next = 16'(len_reg);
                    sh_next    = CW'(k_reg);
                    ins_next   = 1'b0;
                    state_next = facft_pkg::ST_SH_CHK;
                end
                else
                begin
                    gsize_next = 16'(size_reg);
                    state_next = facft_pkg::ST_A_SPLIT;
                end
            end

            facft_pkg::ST_A_SPLIT:
            begin
                // shrink the region from its low end
                alu_op     = facft_pkg::ALU_ADD;
                alu_a      = OW'(start_reg);
                alu_b      = OW'(size_reg);
                ram_we     = 1'b1;
                ram_waddr  = k_reg;
                ram_wdata  = {alu_wrap, left_reg};
                rover_next = k_reg;
                state_next = facft_pkg::ST_DONE;
            end

            facft_pkg::ST_F_RD:
            begin
                ram_raddr  = idx_reg[IW-1:0];
                state_next = facft_pkg::ST_F_LOW;
            end

            facft_pkg::ST_F_LOW:
            begin
                // does this entry end exactly at the freed base?
                start_next = rd_start;
                len_next   = rd_len;
                alu_op     = facft_pkg::ALU_ADD;
                alu_a      = OW'(rd_start);
                alu_b      = OW'(rd_len);
                alu_c      = base_reg;
                if (alu_flags.eq)
                begin
                    hi_next = 1'b0;
                    if (idx_inc < count_reg)
                    begin
                        state_next = facft_pkg::ST_F_NRD;
                    end
                    else
                    begin
                        dbl_next   = 1'b0;
                        state_next = facft_pkg::ST_F_SUM1;
                    end
                end
                else
                begin
                    state_next = facft_pkg::ST_F_ORD;
                end
            end

            facft_pkg::ST_F_ORD:
            begin
                // start below base: keep walking, else this is the insertion point
                alu_op = facft_pkg::ALU_SUB;
                alu_a  = OW'(start_reg);
                alu_b  = OW'(base_reg);
                if (alu_flags.neg)
                begin
                    if (idx_inc == count_reg)
                    begin
                        idx_next   = count_reg;
                        state_next = facft_pkg::ST_INS;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = facft_pkg::ST_F_RD;
                    end
                end
                else
                begin
                    state_next = facft_pkg::ST_F_HIGH;
                end
            end

            facft_pkg::ST_F_HIGH:
            begin
                // freed region ends exactly where this entry starts
                alu_op = facft_pkg::ALU_ADD;
                alu_a  = OW'(base_reg);
                alu_b  = OW'(size_reg);
                alu_c  = start_reg;
                if (alu_flags.eq)
                begin
                    hi_next    = 1'b1;
                    dbl_next   = 1'b0;
                    state_next = facft_pkg::ST_F_SUM1;
                end
                else
                begin
                    state_next = facft_pkg::ST_INS;
                end
            end

            facft_pkg::ST_F_NRD:
            begin
                ram_raddr  = idx_inc[IW-1:0];
                state_next = facft_pkg::ST_F_NCHK;
            end

            facft_pkg::ST_F_NCHK:
            begin
                // upper neighbour touches too: merge all three
                nlen_next  = rd_len;
                alu_op     = facft_pkg::ALU_ADD;
                alu_a      = OW'(base_reg);
                alu_b      = OW'(size_reg);
                alu_c      = rd_start;
                dbl_next   = alu_flags.eq;
                state_next = facft_pkg::ST_F_SUM1;
            end

            facft_pkg::ST_F_SUM1:
            begin
                alu_op = facft_pkg::ALU_ADD;
                alu_a  = OW'(len_reg);
                alu_b  = OW'(size_reg);
                if (dbl_reg)
                begin
                    left_next  = alu_sat;
                    state_next = facft_pkg::ST_F_SUM2;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg[IW-1:0];
                    ram_wdata  = {(hi_reg ? base_reg : start_reg), alu_sat};
                    state_next = facft_pkg::ST_DONE;
                end
            end

            facft_pkg::ST_F_SUM2:
            begin
                // saturation is sticky, so two saturating adds match one wide sum
                alu_op     = facft_pkg::ALU_ADD;
                alu_a      = OW'(left_reg);
                alu_b      = OW'(nlen_reg);
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IW-1:0];
                ram_wdata  = {start_reg, alu_sat};
                sh_next    = idx_inc;
                ins_next   = 1'b0;
                state_next = facft_pkg::ST_SH_CHK;
            end

            facft_pkg::ST_INS:
            begin
                if (count_reg >= CW'(REGIONS))
                begin
                    status_next = facft_pkg::STATUS_TABLE_FULL;
                    state_next  = facft_pkg::ST_DONE;
                end
                else
                begin
                    sh_next    = count_reg;
                    ins_next   = 1'b1;
                    state_next = facft_pkg::ST_SH_CHK;
                end
            end

            facft_pkg::ST_SH_CHK:
            begin
                // insert shifts up from the tail, remove shifts down from the hole
                if (ins_reg)
                begin
                    state_next = (sh_reg == idx_reg) ? facft_pkg::ST_INS_WR
                                                     : facft_pkg::ST_SH_RD;
                end
                else
                begin
                    state_next = (sh_inc >= count_reg) ? facft_pkg::ST_RM_END
                                                       : facft_pkg::ST_SH_RD;
                end
            end

            facft_pkg::ST_SH_RD:
            begin
                ram_raddr  = ins_reg ? sh_dec[IW-1:0] : sh_inc[IW-1:0];
                state_next = facft_pkg::ST_SH_WR;
            end

            facft_pkg::ST_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sh_reg[IW-1:0];
                ram_wdata  = ram_rdata;
                sh_next    = ins_reg ? sh_dec : sh_inc;
                state_next = facft_pkg::ST_SH_CHK;
            end

            facft_pkg::ST_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IW-1:0];
                ram_wdata  = {base_reg, size_reg};
                count_next = count_reg + CW'(1);
                state_next = facft_pkg::ST_DONE;
            end

            facft_pkg::ST_RM_END:
            begin
                count_next = count_dec;
                rover_next = (CW'(rov_cand) >= count_dec) ? '0 : rov_cand;
                state_next = facft_pkg::ST_DONE;
            end

            facft_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = status_reg;
                    rsp_next.grant_base = gbase_reg;
                    rsp_next.grant_size = gsize_reg;
                    state_next          = facft_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = facft_pkg::ST_IDLE;
            end
        endcase

        // a memory_size write reinitializes the table
        if (cfg_we && cfg_index == facft_pkg::REG_MEMORY_SIZE)
        begin
            state_next = facft_pkg::ST_INIT;
        end
    end

endmodule

/* sv/facft_ram.sv */
module facft_ram #(
    parameter int DEPTH = facft_pkg::REGIONS_DEFAULT,
    parameter int WIDTH = 2 * facft_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/facft_alu.sv */
module facft_alu #(
    parameter int ADDR_BITS = facft_pkg::ADDR_BITS_DEFAULT
) (
    input  facft_pkg::alu_op_t                                op,
    input  logic [facft_pkg::operand_width(ADDR_BITS)-1:0]    a,
    input  logic [facft_pkg::operand_width(ADDR_BITS)-1:0]    b,
    input  logic [ADDR_BITS-1:0]                              c,
    output logic [ADDR_BITS-1:0]                              sum_wrap,
    output logic [ADDR_BITS-1:0]                              sum_sat,
    output facft_pkg::alu_flags_t                             flags
);

    localparam int W  = ADDR_BITS;
    localparam int OW = facft_pkg::operand_width(ADDR_BITS);

    logic [OW-1:0] res;

    always_comb
    begin
        case (op)
            facft_pkg::ALU_ADD: res = a + b;
            facft_pkg::ALU_SUB: res = a - b;
            default:            res = a + b;
        endcase
    end

    // operands stay below the top bit, so the top bit of a difference is the borrow
    assign flags.neg = res[OW-1];
    assign flags.eq  = (res == OW'(c));
    assign sum_wrap  = res[W-1:0];
    assign sum_sat   = (|res[OW-1:W]) ? {W{1'b1}} : res[W-1:0];

endmodule

/* tb/sv/fit_allocator_checker.sv */
module fit_allocator_checker #(
    parameter int REGIONS = facft_pkg::REGIONS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    input  logic                                 req_stall,
    input  facft_pkg::req_t                      req,
    input  logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    input  facft_pkg::rsp_t                      rsp,
    input  logic                                 cfg_we,
    input  logic [facft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [facft_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                   failures,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import facft_pkg::*;

    localparam int unsigned ADDR_MAX = (1 << ADDR_BITS_DEFAULT) - 1;

    // Mirror of the free table, sorted by base address.
    logic [FIELD_BITS-1:0] hole_base [REGIONS];
    logic [FIELD_BITS-1:0] hole_len  [REGIONS];
    int unsigned           hole_count;
    int unsigned           search_from;
    policy_t               policy;
    logic [FIELD_BITS-1:0] gap_limit;
    logic [FIELD_BITS-1:0] mem_units;
    rsp_t                  due_grants [$];

    function automatic logic [FIELD_BITS-1:0] saturate(input int unsigned v);
        return FIELD_BITS'((v > ADDR_MAX) ? ADDR_MAX : v);
    endfunction

    function automatic void reset_holes();
        for (int i = 0; i < REGIONS; i++)
        begin
            hole_base[i] = '0;
            hole_len[i]  = '0;
        end
        hole_len[0] = mem_units;
        hole_count  = (mem_units == 0) ? 0 : 1;
        search_from = 0;
    endfunction

    function automatic void retire_hole(input int unsigned k);
        for (int unsigned j = k; j + 1 < hole_count; j++)
        begin
            hole_base[j] = hole_base[j + 1];
            hole_len[j]  = hole_len[j + 1];
        end
        hole_count--;
    endfunction

    function automatic logic open_hole(input int unsigned k, input logic [FIELD_BITS-1:0] at,
                                       input logic [FIELD_BITS-1:0] units);
        if (hole_count >= REGIONS)
            return 1'b0;
        for (int unsigned j = hole_count; j > k; j--)
        begin
            hole_base[j] = hole_base[j - 1];
            hole_len[j]  = hole_len[j - 1];
        end
        hole_base[k] = at;
        hole_len[k]  = units;
        hole_count++;
        return 1'b1;
    endfunction

    // Allocate: pick the hole, then grant it whole or split off its low end.
    function automatic rsp_t carve_region(input logic [FIELD_BITS-1:0] units);
        rsp_t        r;
        int unsigned first;
        int unsigned k;
        int          hit;
        r        = '0;
        r.status = STATUS_NO_FIT;
        if (units == 0)
            return r;
        first = 0;
        if (policy == POLICY_NEXT)
        begin
            if (search_from >= hole_count)
                search_from = 0;
            first = search_from;
        end
        hit = -1;
        for (int unsigned i = 0; i < hole_count && hit < 0; i++)
        begin
            k = first + i;
            if (k >= hole_count)
                k -= hole_count;
            if (hole_len[k] >= units)
                hit = k;
        end
        if (hit < 0)
            return r;
        k            = hit;
        r.status     = STATUS_OK;
        r.grant_base = hole_base[k];
        if (hole_len[k] - units <= gap_limit)
        begin
            r.grant_size = hole_len[k];
            retire_hole(k);
        end
        else
        begin
            r.grant_size = units;
            hole_base[k] = hole_base[k] + units;
            hole_len[k]  = hole_len[k] - units;
        end
        search_from = k;
        if (search_from >= hole_count)
            search_from = 0;
        return r;
    endfunction

    // Free: coalesce with the hole below and/or above, else insert in order.
    function automatic status_t return_region(input logic [FIELD_BITS-1:0] at,
                                              input logic [FIELD_BITS-1:0] units);
        int unsigned tail;
        tail = at + units;
        if (units == 0)
            return STATUS_OK;
        for (int unsigned i = 0; i < hole_count; i++)
        begin
            if ({1'b0, hole_base[i]} + hole_len[i] == at)
            begin
                if (i + 1 < hole_count && tail == hole_base[i + 1])
                begin
                    hole_len[i] = saturate(32'(hole_len[i]) + units + hole_len[i + 1]);
                    retire_hole(i + 1);
                    if (search_from >= hole_count)
                        search_from = 0;
                end
                else
                    hole_len[i] = saturate(32'(hole_len[i]) + units);
                return STATUS_OK;
            end
            if (hole_base[i] < at)
                continue;
            if (tail == hole_base[i])
            begin
                hole_base[i] = at;
                hole_len[i]  = saturate(32'(units) + hole_len[i]);
                return STATUS_OK;
            end
            return open_hole(i, at, units) ? STATUS_OK : STATUS_TABLE_FULL;
        end
        return open_hole(hole_count, at, units) ? STATUS_OK : STATUS_TABLE_FULL;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            policy    = POLICY_FIRST;
            gap_limit = GAP_RESET;
            mem_units = MEMORY_SIZE_RESET;
            reset_holes();
            due_grants.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            // result side first: a result never belongs to a request taken on the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (due_grants.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected result status %0d base %h size %h",
                                 $realtime, rsp.status, rsp.grant_base, rsp.grant_size);
                end
                else
                begin
                    want = due_grants.pop_front();
                    if (rsp.status != want.status || rsp.grant_base != want.grant_base ||
                        rsp.grant_size != want.grant_size)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: mismatch status %0d/%0d base %h/%h size %h/%h %s",
                                     $realtime, want.status, rsp.status, want.grant_base,
                                     rsp.grant_base, want.grant_size, rsp.grant_size,
                                     "(expected/actual)");
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FIT_POLICY:  policy = policy_t'(cfg_data[0]);
                    REG_GAP:         gap_limit = cfg_data;
                    REG_MEMORY_SIZE:
                    begin
                        mem_units = cfg_data;
                        reset_holes();
                    end
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
            begin
                if (req.command == CMD_ALLOC)
                    due_grants.push_back(carve_region(req.size));
                else
                begin
                    want        = '0;
                    want.status = return_region(req.base, req.size);
                    due_grants.push_back(want);
                end
            end
            outstanding = due_grants.size();
        end
    end

endmodule

/* tb/sv/fit_allocator_coalescing_free_table_tb.sv */
module fit_allocator_coalescing_free_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import facft_pkg::*;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    req_t                      req       = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    rsp_t                      rsp;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    int                        failures;
    int                        outstanding;

    // Idle percentages for the request sender and the result receiver.
    int send_pct  = 0;
    int stall_pct = 0;
    // Size of the managed space in the current phase; shapes random sizes and bases.
    int mem_now   = 65535;

    // Commands in the order their transfers were taken, and the blocks granted
    // so far in this phase, packed as {base, size}, for well-formed frees.
    cmd_t        sent_cmds   [$];
    logic [31:0] held_blocks [$];

    fit_allocator_coalescing_free_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fit_allocator_checker grant_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // Receiver back-pressure: redraw the stall once per cycle on the falling edge.
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Record every granted block so later frees can hand it back. The transfer
    // that carries a result always belongs to an older request than any request
    // taken on the same edge, so popping the front is safe.
    always @(posedge clk)
    begin : track_grants
        if (rst_n && rsp_valid && !rsp_stall && sent_cmds.size() != 0)
        begin
            if (sent_cmds.pop_front() == CMD_ALLOC && rsp.status == STATUS_OK)
                held_blocks.push_back({rsp.grant_base, rsp.grant_size});
        end
    end

    // Present one request and hold it until its transfer. Valid stays high
    // after the transfer; the next call either drops it while the sender idles or
    // replaces the payload, so each falling edge carries one update at most.
    task automatic send_req(input cmd_t c, input logic [FIELD_BITS-1:0] units,
                            input logic [FIELD_BITS-1:0] at);
        req_t item;
        item.command = c;
        item.size    = units;
        item.base    = at;
        while ($urandom_range(99) < send_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        sent_cmds.push_back(c);
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic drain_all();
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                    roll;
        int                    pick;
        int                    cap;
        logic [31:0]           blk;
        logic [FIELD_BITS-1:0] gap_val;
        logic [FIELD_BITS-1:0] mem_val;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: first fit, gap of five, space of 65535 units.
        send_req(CMD_ALLOC, 16'd0, 16'hFFFF);      // zero-unit request never fits
        send_req(CMD_ALLOC, 16'd100, 16'h0000);    // split from the low end
        send_req(CMD_FREE, 16'd0, 16'h0000);       // zero-unit free leaves the table alone
        send_req(CMD_FREE, 16'd100, 16'h0000);     // merge into the hole above
        send_req(CMD_ALLOC, 16'd65533, 16'h0000);  // leftover within gap: whole hole, table empty
        send_req(CMD_FREE, 16'hFFFF, 16'hFFFF);    // out-of-range region goes in as is
        send_req(CMD_FREE, 16'hFFFF, 16'h0000);    // merge above, length saturates
        send_req(CMD_ALLOC, 16'hFFFF, 16'h0000);   // largest request

        // Next fit, no gap, empty table: fill it, overflow it, then coalesce while full.
        drain_all();
        write_reg(REG_FIT_POLICY, POLICY_NEXT);
        write_reg(REG_GAP, 16'd0);
        write_reg(REG_MEMORY_SIZE, 16'd0);
        for (int i = 0; i < 17; i++)
            send_req(CMD_FREE, 16'd2, FIELD_BITS'(i * 4)); // the last one finds the table full
        send_req(CMD_FREE, 16'd2, 16'd2);          // joins both neighbours, frees one entry
        send_req(CMD_FREE, 16'd12, 16'd100);       // new hole at the tail
        send_req(CMD_ALLOC, 16'd8, 16'd0);         // only the tail fits; search moves there
        send_req(CMD_ALLOC, 16'd5, 16'd0);         // tail too short: wrap and split the head
        send_req(CMD_ALLOC, 16'd3, 16'd0);         // tail again, one unit left
        send_req(CMD_ALLOC, 16'd2, 16'd0);         // tail too short: wrap to the head

        // Random phases. Idle pattern cycles through none, sender, receiver, both;
        // the first four run first fit, the last four next fit.
        for (int p = 0; p < 8; p++)
        begin
            drain_all();
            case (p % 4)
                0:
                begin
                    send_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_pct  = 48;
                    stall_pct = 0;
                end
                2:
                begin
                    send_pct  = 0;
                    stall_pct = 48;
                end
                default:
                begin
                    send_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            case (p)
                0:
                begin
                    gap_val = 16'd0;
                    mem_val = 16'd4096;
                end
                1:
                begin
                    gap_val = 16'd5;
                    mem_val = 16'd200;
                end
                2:
                begin
                    gap_val = 16'hFFFF;
                    mem_val = 16'd1;
                end
                3:
                begin
                    gap_val = FIELD_BITS'($urandom_range(0, 32));
                    mem_val = 16'hFFFF;
                end
                4:
                begin
                    gap_val = 16'd2;
                    mem_val = 16'd64;
                end
                5:
                begin
                    gap_val = FIELD_BITS'($urandom_range(0, 16));
                    mem_val = FIELD_BITS'($urandom_range(16, 2048));
                end
                6:
                begin
                    gap_val = 16'hFFFF;
                    mem_val = 16'd1000;
                end
                default:
                begin
                    gap_val = 16'd9;
                    mem_val = FIELD_BITS'($urandom);
                end
            endcase
            write_reg(REG_FIT_POLICY, (p >= 4) ? POLICY_NEXT : POLICY_FIRST);
            write_reg(REG_GAP, gap_val);
            write_reg(REG_MEMORY_SIZE, mem_val);
            mem_now = int'(mem_val);
            held_blocks.delete();
            cap = (mem_now / 6 > 1) ? mem_now / 6 : 1;

            // Mostly allocate and hand back granted blocks; the rest is noise:
            // overlapping frees inside the space, and fully random fields.
            repeat (250)
            begin
                roll = $urandom_range(99);
                if (roll >= 40 && roll < 72 && held_blocks.size() != 0)
                begin
                    pick = $urandom_range(held_blocks.size() - 1);
                    blk  = held_blocks[pick];
                    held_blocks.delete(pick);
                    send_req(CMD_FREE, blk[15:0], blk[31:16]);
                end
                else if (roll < 72)
                    send_req(CMD_ALLOC, FIELD_BITS'($urandom_range(1, cap)),
                             FIELD_BITS'($urandom));
                else if (roll < 80)
                    send_req(CMD_FREE, FIELD_BITS'($urandom_range(1, cap / 2 + 1)),
                             FIELD_BITS'($urandom_range(0, mem_now)));
                else if (roll < 88)
                    send_req(CMD_ALLOC, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
                else
                    send_req(CMD_FREE, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
            end
        end

        // Let the last results land, then catch any stray result before the verdict.
        drain_all();
        repeat (150) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run of every phase.
    initial
    begin : watchdog
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/facft_pkg.sv
sv/facft_ram.sv
sv/facft_alu.sv
sv/fit_allocator_coalescing_free_table.sv
tb/sv/fit_allocator_checker.sv
tb/sv/fit_allocator_coalescing_free_table_tb.sv
